// ===== rtl/core/nrsm_pkg.sv =====
// Shared types, constants and the arctangent table of the nearest road segment matcher.
`timescale 1ns / 1ps
package nrsm_pkg;

	// shared multiplier operand and product widths
	localparam int MW = 35;
	localparam int PW = 2 * MW;

	localparam logic [30:0] DIST_SENTINEL = 31'h7FFF_FFFF;
	localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
	localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;   // 0.607252935 in Q30
	localparam logic [MW-1:0] DEG_TO_BAM  = 35'd1281023894;  // 1e-7 deg to 2^32/360, Q30
	localparam logic [MW-1:0] EARTH_CIRC  = 35'd4003017359;  // 2*pi*6371 km in cm

	// last iteration index of the shift-subtract unit, per mode
	localparam logic [4:0] DIV_LAST  = 5'd29;
	localparam logic [4:0] SQRT_LAST = 5'd31;

	typedef struct packed {
		logic start;
		logic vect;
	} cor_cmd_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} sqd_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// atan(2^-i) as binary angle, 2^32 = 360 degrees
	function automatic logic [30:0] atan_bam(input logic [4:0] idx);
		logic [30:0] r;
		case (idx)
			5'd0:  r = 31'd536870912;
			5'd1:  r = 31'd316933406;
			5'd2:  r = 31'd167458907;
			5'd3:  r = 31'd85004756;
			5'd4:  r = 31'd42667331;
			5'd5:  r = 31'd21354465;
			5'd6:  r = 31'd10679838;
			5'd7:  r = 31'd5340245;
			5'd8:  r = 31'd2670163;
			5'd9:  r = 31'd1335087;
			5'd10: r = 31'd667544;
			5'd11: r = 31'd333772;
			5'd12: r = 31'd166886;
			5'd13: r = 31'd83443;
			5'd14: r = 31'd41722;
			5'd15: r = 31'd20861;
			5'd16: r = 31'd10430;
			5'd17: r = 31'd5215;
			5'd18: r = 31'd2608;
			5'd19: r = 31'd1304;
			5'd20: r = 31'd652;
			5'd21: r = 31'd326;
			5'd22: r = 31'd163;
			5'd23: r = 31'd81;
			5'd24: r = 31'd41;
			5'd25: r = 31'd20;
			5'd26: r = 31'd10;
			5'd27: r = 31'd5;
			5'd28: r = 31'd3;
			5'd29: r = 31'd1;
			5'd30: r = 31'd1;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/nrsm_seg_if.sv =====
// Segment input channel: handshake and segment item payload.
`timescale 1ns / 1ps
interface nrsm_seg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] query_lon;
	logic signed [30:0] query_lat;
	logic signed [31:0] end_a_lon;
	logic signed [30:0] end_a_lat;
	logic signed [31:0] end_b_lon;
	logic signed [30:0] end_b_lat;
	logic [15:0]        segment_id;
	logic               final_segment;

	modport source (
		output valid, query_lon, query_lat, end_a_lon, end_a_lat,
		output end_b_lon, end_b_lat, segment_id, final_segment,
		input  ready
	);
	modport sink (
		input  valid, query_lon, query_lat, end_a_lon, end_a_lat,
		input  end_b_lon, end_b_lat, segment_id, final_segment,
		output ready
	);
endinterface

// ===== rtl/core/nrsm_match_if.sv =====
// Match result channel: handshake and best match payload.
`timescale 1ns / 1ps
interface nrsm_match_if;
	logic               valid;
	logic               ready;
	logic [15:0]        best_id;
	logic signed [31:0] proj_lon;
	logic signed [30:0] proj_lat;
	logic [30:0]        best_distance;

	modport source (
		output valid, best_id, proj_lon, proj_lat, best_distance,
		input  ready
	);
	modport sink (
		input  valid, best_id, proj_lon, proj_lat, best_distance,
		output ready
	);
endinterface

// ===== rtl/core/nrsm_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module nrsm_mul
	import nrsm_pkg::*;
(
	input  logic                 clk,
	input  logic signed [MW-1:0] a,
	input  logic signed [MW-1:0] b,
	output logic signed [PW-1:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

// ===== rtl/core/nrsm_cordic.sv =====
// Iterative CORDIC unit: rotation for sin/cos, vectoring for atan2.
`timescale 1ns / 1ps
module nrsm_cordic
	import nrsm_pkg::*;
#(
	parameter int STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cor_cmd_t           cmd,
	input  logic [31:0]        ang,
	input  logic [30:0]        x_in,
	input  logic [30:0]        y_in,
	output unit_stat_t         stat,
	output logic signed [33:0] x_out,
	output logic signed [33:0] y_out,
	output logic signed [33:0] z_out
);

	localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [SW-1:0] LAST = SW'(STEPS - 1);

	logic              busy_q, done_q;
	logic              vect_q, neg_q;
	logic [SW-1:0]     i_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] xs, ys, at;
	logic              sigma;
	logic [31:0]       sum, fold;
	logic              wrap;

	always_comb begin
		// fold angles beyond +-90 deg by 180 deg, negate results afterwards
		sum   = ang + 32'h4000_0000;
		wrap  = sum[31];
		fold  = wrap ? (ang + 32'h8000_0000) : ang;
		xs    = x_q >>> i_q;
		ys    = y_q >>> i_q;
		at    = $signed({3'b000, atan_bam(5'(i_q))});
		sigma = vect_q ? y_q[33] : ~z_q[33];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vect_q <= cmd.vect;
			neg_q  <= ~cmd.vect & wrap;
			x_q    <= cmd.vect ? $signed({3'b000, x_in}) : $signed(CORDIC_GAIN);
			y_q    <= cmd.vect ? $signed({3'b000, y_in}) : 34'sd0;
			z_q    <= cmd.vect ? 34'sd0 : $signed({{2{fold[31]}}, fold});
		end else if (busy_q) begin
			if (sigma) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign x_out = neg_q ? -x_q : x_q;
	assign y_out = neg_q ? -y_q : y_q;
	assign z_out = z_q;
	assign stat  = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/core/nrsm_sqdiv.sv =====
// Bit-serial shift-subtract unit: restoring divide (Q30 quotient) or integer square root.
`timescale 1ns / 1ps
module nrsm_sqdiv
	import nrsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sqd_cmd_t    cmd,
	input  logic [62:0] num,
	input  logic [60:0] den,
	output unit_stat_t  stat,
	output logic [62:0] res
);

	logic        busy_q, done_q, sqrt_q;
	logic [4:0]  cnt_q;
	logic [62:0] rem_q, acc_q, b_q;
	logic [60:0] den_q;
	logic [62:0] lhs, rhs, diff;
	logic        ge;

	always_comb begin
		// one shared compare-subtract serves both operations
		lhs  = sqrt_q ? rem_q : {rem_q[61:0], 1'b0};
		rhs  = sqrt_q ? (acc_q + b_q) : {2'b00, den_q};
		ge   = (lhs >= rhs);
		diff = lhs - rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == (sqrt_q ? SQRT_LAST : DIV_LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.sqrt;
			rem_q  <= num;
			acc_q  <= '0;
			// root bit walks down from 4^31, two places per step
			b_q    <= {1'b1, 62'd0};
			den_q  <= den;
		end else if (busy_q) begin
			if (sqrt_q) begin
				rem_q <= ge ? diff : rem_q;
				acc_q <= ge ? ((acc_q >> 1) + b_q) : (acc_q >> 1);
				b_q   <= b_q >> 2;
			end else begin
				rem_q <= ge ? diff : lhs;
				acc_q <= {acc_q[61:0], ge};
			end
		end
	end

	assign res  = acc_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/core/nearest_road_segment_match_core.sv =====
// Top level of the nearest road segment matcher: sequencer, datapath registers, running minimum.
`timescale 1ns / 1ps
// Matches one query position against a stream of road segments, one segment item at a
// time. Each item's query point is projected onto segment A-B in degree space (parameter
// clamped to 0..1), the haversine distance from the projected point to the query is
// formed in centimetres, and the running minimum is kept (ties go to the later segment).
// An item with final_segment set is compared first; then the best road id, projected
// point and distance leave as one result item and the running state clears. Coordinates
// are signed 1e-7 degree. The time between accepts is set by one shared multiplier, a
// bit-serial divider that runs 30 steps and is skipped when the projection parameter
// clamps, two 32-step square roots, and five passes of a single CORDIC unit (four
// sin/cos, one atan2); CORDIC_STEPS above 32 count as 32. seg.ready is high only between
// items. The result sits in an output register, so the next item is taken while a result
// still waits; a final item whose result finds that register still full holds until it
// is taken.
module nearest_road_segment_match_core
	import nrsm_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	nrsm_seg_if.sink     seg,
	nrsm_match_if.source best
);

	localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

	// sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_NRM0 = 5'd1;
	localparam logic [4:0] S_NRM1 = 5'd2;
	localparam logic [4:0] S_DOT0 = 5'd3;
	localparam logic [4:0] S_DOT1 = 5'd4;
	localparam logic [4:0] S_UDEC = 5'd5;
	localparam logic [4:0] S_DIV  = 5'd6;
	localparam logic [4:0] S_OFF0 = 5'd7;
	localparam logic [4:0] S_OFF1 = 5'd8;
	localparam logic [4:0] S_OFF2 = 5'd9;
	localparam logic [4:0] S_BAM1 = 5'd10;
	localparam logic [4:0] S_BAM2 = 5'd11;
	localparam logic [4:0] S_BAM3 = 5'd12;
	localparam logic [4:0] S_BAM4 = 5'd13;
	localparam logic [4:0] S_CST  = 5'd14;
	localparam logic [4:0] S_CWT  = 5'd15;
	localparam logic [4:0] S_H0   = 5'd16;
	localparam logic [4:0] S_H1   = 5'd17;
	localparam logic [4:0] S_H2   = 5'd18;
	localparam logic [4:0] S_H3   = 5'd19;
	localparam logic [4:0] S_H4   = 5'd20;
	localparam logic [4:0] S_H5   = 5'd21;
	localparam logic [4:0] S_SQY  = 5'd22;
	localparam logic [4:0] S_SQX  = 5'd23;
	localparam logic [4:0] S_VEC  = 5'd24;
	localparam logic [4:0] S_DST0 = 5'd25;
	localparam logic [4:0] S_DST1 = 5'd26;
	localparam logic [4:0] S_FIN  = 5'd27;

	// CORDIC pass order
	localparam logic [1:0] RUN_DLAT = 2'd0;
	localparam logic [1:0] RUN_DLON = 2'd1;
	localparam logic [1:0] RUN_PLAT = 2'd2;
	localparam logic [1:0] RUN_QLAT = 2'd3;

	function automatic logic [33:0] mag34(input logic [33:0] v);
		return v[33] ? (34'd0 - v) : v;
	endfunction

	// control state
	logic [4:0]  state_q;
	logic [1:0]  cidx_q;
	logic        out_valid_q;
	logic [30:0] min_dist_q;
	logic [15:0] min_id_q;
	logic [31:0] min_plon_q;
	logic [30:0] min_plat_q;

	// item and working registers
	logic [31:0] qlon_q, blon_q;
	logic [30:0] qlat_q, blat_q;
	logic [15:0] id_q;
	logic        fin_q;
	logic [32:0] px_q, qx_q;
	logic [31:0] py_q, qy_q;
	logic signed [62:0] acc_q;
	logic [60:0] norm_q;
	logic [30:0] u_q;
	logic [31:0] plon_q;
	logic [30:0] plat_q;
	logic [31:0] bp_q, bq_q, bql_q, bpl_q;
	logic [33:0] s1_q, s2_q, c1_q, c2_q, cc_q;
	logic [31:0] sq1_q, sq2_q;
	logic [30:0] h_q, y0_q;
	logic [31:0] ang_q;
	logic [15:0] out_id_q;
	logic [31:0] out_plon_q;
	logic [30:0] out_plat_q;
	logic [30:0] out_dist_q;

	// datapath
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;
	logic [PW-1:0]        rnd29, rnd31;
	logic [31:0]          bam_mag;
	logic [32:0]          off_mag;
	logic [33:0]          off;
	logic [62:0]          dot_c;
	logic                 div_go;
	logic [31:0]          dlat, dlon, cor_ang;
	logic [34:0]          hp;
	logic [35:0]          h_c;
	logic [30:0]          h_new;
	logic [30:0]          dist_c;
	logic [33:0]          z_c;
	logic [30:0]          zcl;
	logic                 out_load;
	logic                 take;

	cor_cmd_t             cor_cmd;
	unit_stat_t           cor_stat;
	logic signed [33:0]   cor_x, cor_y, cor_z;
	sqd_cmd_t             sqd_cmd;
	unit_stat_t           sqd_stat;
	logic [62:0]          sqd_num, sqd_res;

	nrsm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	nrsm_cordic #(.STEPS(NSTEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cor_cmd),
		.ang    (cor_ang),
		.x_in   (sqd_res[30:0]),
		.y_in   (y0_q),
		.stat   (cor_stat),
		.x_out  (cor_x),
		.y_out  (cor_y),
		.z_out  (cor_z)
	);

	nrsm_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (sqd_cmd),
		.num    (sqd_num),
		.den    (norm_q),
		.stat   (sqd_stat),
		.res    (sqd_res)
	);

	assign take = seg.valid & seg.ready;

	always_comb begin
		// rounding helpers on the registered product
		rnd29   = mul_p + PW'(64'h2000_0000);
		rnd31   = mul_p + PW'(64'h8000_0000);
		bam_mag = rnd29[61:30];
		off_mag = rnd29[62:30];
		dist_c  = rnd31[62:32];

		// dot product completes in S_UDEC; u = 0, 1 or a bit-serial quotient
		dot_c  = acc_q + mul_p[62:0];
		div_go = (norm_q != '0) && !dot_c[62] && (dot_c != '0) &&
		         (dot_c < {2'b00, norm_q});

		// half angle differences, arithmetic shift of the wrapped difference
		dlat = bq_q - bp_q;
		dlon = bql_q - bpl_q;
		case (cidx_q)
			RUN_DLAT: cor_ang = {dlat[31], dlat[31:1]};
			RUN_DLON: cor_ang = {dlon[31], dlon[31:1]};
			RUN_PLAT: cor_ang = bp_q;
			RUN_QLAT: cor_ang = bq_q;
			default:  cor_ang = bq_q;
		endcase

		// h = s1^2 + cc * s2^2, clamped to 0..1 in Q30
		hp  = mul_p[64:30];
		h_c = {4'd0, sq1_q} + {hp[34], hp};
		if (h_c[35]) begin
			h_new = '0;
		end else if (h_c > {5'd0, Q30_ONE}) begin
			h_new = Q30_ONE;
		end else begin
			h_new = h_c[30:0];
		end

		// atan2 result clamped to 0..90 deg
		z_c = cor_z;
		if (z_c[33]) begin
			zcl = '0;
		end else if (z_c > {3'd0, Q30_ONE}) begin
			zcl = Q30_ONE;
		end else begin
			zcl = z_c[30:0];
		end

		out_load = (state_q == S_FIN) && fin_q && (!out_valid_q || best.ready);
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_NRM0: begin
				mul_a = $signed({{4{px_q[32]}}, px_q[32:2]});
				mul_b = $signed({{4{px_q[32]}}, px_q[32:2]});
			end
			S_NRM1: begin
				mul_a = $signed({{5{py_q[31]}}, py_q[31:2]});
				mul_b = $signed({{5{py_q[31]}}, py_q[31:2]});
			end
			S_DOT0: begin
				mul_a = $signed({{4{px_q[32]}}, px_q[32:2]});
				mul_b = $signed({{4{qx_q[32]}}, qx_q[32:2]});
			end
			S_DOT1: begin
				mul_a = $signed({{5{py_q[31]}}, py_q[31:2]});
				mul_b = $signed({{5{qy_q[31]}}, qy_q[31:2]});
			end
			S_OFF0: begin
				mul_a = $signed({1'b0, mag34({px_q[32], px_q})});
				mul_b = $signed({4'd0, u_q});
			end
			S_OFF1: begin
				mul_a = $signed({1'b0, mag34({{2{py_q[31]}}, py_q})});
				mul_b = $signed({4'd0, u_q});
			end
			S_OFF2: begin
				mul_a = $signed({1'b0, mag34({{3{qlat_q[30]}}, qlat_q})});
				mul_b = $signed(DEG_TO_BAM);
			end
			S_BAM1: begin
				mul_a = $signed({1'b0, mag34({{2{qlon_q[31]}}, qlon_q})});
				mul_b = $signed(DEG_TO_BAM);
			end
			S_BAM2: begin
				mul_a = $signed({1'b0, mag34({{2{plon_q[31]}}, plon_q})});
				mul_b = $signed(DEG_TO_BAM);
			end
			S_BAM3: begin
				mul_a = $signed({1'b0, mag34({{3{plat_q[30]}}, plat_q})});
				mul_b = $signed(DEG_TO_BAM);
			end
			S_H0: begin
				mul_a = $signed({c1_q[33], c1_q});
				mul_b = $signed({c2_q[33], c2_q});
			end
			S_H1: begin
				mul_a = $signed({1'b0, mag34(s1_q)});
				mul_b = $signed({1'b0, mag34(s1_q)});
			end
			S_H2: begin
				mul_a = $signed({1'b0, mag34(s2_q)});
				mul_b = $signed({1'b0, mag34(s2_q)});
			end
			S_H4: begin
				mul_a = $signed({cc_q[33], cc_q});
				mul_b = $signed({3'd0, sq2_q});
			end
			S_DST0: begin
				mul_a = $signed({3'd0, ang_q});
				mul_b = $signed(EARTH_CIRC);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// unit commands
	always_comb begin
		cor_cmd.start = (state_q == S_CST) || ((state_q == S_SQX) && sqd_stat.done);
		cor_cmd.vect  = (state_q == S_SQX);
		sqd_cmd.start = ((state_q == S_UDEC) && div_go) || (state_q == S_H5) ||
		                ((state_q == S_SQY) && sqd_stat.done);
		sqd_cmd.sqrt  = (state_q != S_UDEC);
		case (state_q)
			S_UDEC:  sqd_num = dot_c;
			S_H5:    sqd_num = {2'b00, h_new, 30'd0};
			default: sqd_num = {2'b00, Q30_ONE - h_q, 30'd0};
		endcase
		off = px_q[32] ? (34'd0 - {1'b0, off_mag}) : {1'b0, off_mag};
		if (state_q == S_OFF2) begin
			off = py_q[31] ? (34'd0 - {1'b0, off_mag}) : {1'b0, off_mag};
		end
	end

	// sequencer and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cidx_q      <= RUN_DLAT;
			out_valid_q <= 1'b0;
			min_dist_q  <= DIST_SENTINEL;
			min_id_q    <= '0;
			min_plon_q  <= '0;
			min_plat_q  <= '0;
		end else begin
			if (out_valid_q && best.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_NRM0;
					end
				end
				S_NRM0: state_q <= S_NRM1;
				S_NRM1: state_q <= S_DOT0;
				S_DOT0: state_q <= S_DOT1;
				S_DOT1: state_q <= S_UDEC;
				S_UDEC: state_q <= div_go ? S_DIV : S_OFF0;
				S_DIV: begin
					if (sqd_stat.done) begin
						state_q <= S_OFF0;
					end
				end
				S_OFF0: state_q <= S_OFF1;
				S_OFF1: state_q <= S_OFF2;
				S_OFF2: state_q <= S_BAM1;
				S_BAM1: state_q <= S_BAM2;
				S_BAM2: state_q <= S_BAM3;
				S_BAM3: state_q <= S_BAM4;
				S_BAM4: begin
					cidx_q  <= RUN_DLAT;
					state_q <= S_CST;
				end
				S_CST: state_q <= S_CWT;
				S_CWT: begin
					if (cor_stat.done) begin
						if (cidx_q == RUN_QLAT) begin
							state_q <= S_H0;
						end else begin
							cidx_q  <= cidx_q + 1'b1;
							state_q <= S_CST;
						end
					end
				end
				S_H0: state_q <= S_H1;
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: state_q <= S_H4;
				S_H4: state_q <= S_H5;
				S_H5: state_q <= S_SQY;
				S_SQY: begin
					if (sqd_stat.done) begin
						state_q <= S_SQX;
					end
				end
				S_SQX: begin
					if (sqd_stat.done) begin
						state_q <= S_VEC;
					end
				end
				S_VEC: begin
					if (cor_stat.done) begin
						state_q <= S_DST0;
					end
				end
				S_DST0: state_q <= S_DST1;
				S_DST1: begin
					// later segment wins a tie
					if (dist_c <= min_dist_q) begin
						min_dist_q <= dist_c;
						min_id_q   <= id_q;
						min_plon_q <= plon_q;
						min_plat_q <= plat_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (out_load) begin
						out_valid_q <= 1'b1;
						min_dist_q  <= DIST_SENTINEL;
						min_id_q    <= '0;
						min_plon_q  <= '0;
						min_plat_q  <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (take) begin
			qlon_q <= seg.query_lon;
			qlat_q <= seg.query_lat;
			blon_q <= seg.end_b_lon;
			blat_q <= seg.end_b_lat;
			id_q   <= seg.segment_id;
			fin_q  <= seg.final_segment;
			px_q   <= {seg.end_a_lon[31], seg.end_a_lon} - {seg.end_b_lon[31], seg.end_b_lon};
			py_q   <= {seg.end_a_lat[30], seg.end_a_lat} - {seg.end_b_lat[30], seg.end_b_lat};
			qx_q   <= {seg.query_lon[31], seg.query_lon} - {seg.end_b_lon[31], seg.end_b_lon};
			qy_q   <= {seg.query_lat[30], seg.query_lat} - {seg.end_b_lat[30], seg.end_b_lat};
		end
		case (state_q)
			S_NRM1: acc_q  <= mul_p[62:0];
			S_DOT0: norm_q <= 61'(acc_q + mul_p[62:0]);
			S_DOT1: acc_q  <= mul_p[62:0];
			S_UDEC: begin
				if (!div_go) begin
					u_q <= (!dot_c[62] && (dot_c != '0) && (norm_q != '0)) ? Q30_ONE : '0;
				end
			end
			S_DIV: begin
				if (sqd_stat.done) begin
					u_q <= sqd_res[30:0];
				end
			end
			S_OFF1: plon_q <= 32'({{2{blon_q[31]}}, blon_q} + off);
			S_OFF2: plat_q <= 31'({{3{blat_q[30]}}, blat_q} + off);
			S_BAM1: bq_q  <= qlat_q[30] ? (32'd0 - bam_mag) : bam_mag;
			S_BAM2: bql_q <= qlon_q[31] ? (32'd0 - bam_mag) : bam_mag;
			S_BAM3: bpl_q <= plon_q[31] ? (32'd0 - bam_mag) : bam_mag;
			S_BAM4: bp_q  <= plat_q[30] ? (32'd0 - bam_mag) : bam_mag;
			S_CWT: begin
				if (cor_stat.done) begin
					case (cidx_q)
						RUN_DLAT: s1_q <= cor_y;
						RUN_DLON: s2_q <= cor_y;
						RUN_PLAT: c1_q <= cor_x;
						default:  c2_q <= cor_x;
					endcase
				end
			end
			S_H1: cc_q  <= mul_p[63:30];
			S_H2: sq1_q <= rnd29[61:30];
			S_H3: sq2_q <= rnd29[61:30];
			S_H5: h_q   <= h_new;
			S_SQY: begin
				if (sqd_stat.done) begin
					y0_q <= sqd_res[30:0];
				end
			end
			S_VEC: begin
				if (cor_stat.done) begin
					ang_q <= {zcl, 1'b0};
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_id_q   <= min_id_q;
			out_plon_q <= min_plon_q;
			out_plat_q <= min_plat_q;
			out_dist_q <= min_dist_q;
		end
	end

	assign seg.ready          = (state_q == S_IDLE);
	assign best.valid         = out_valid_q;
	assign best.best_id       = out_id_q;
	assign best.proj_lon      = out_plon_q;
	assign best.proj_lat      = out_plat_q;
	assign best.best_distance = out_dist_q;

	// one item at a time: no accept in the cycle after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !seg.ready)
		else $error("segment item accepted while previous item in flight");

	// emitting a result restores the running minimum to its sentinel
	a_min_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (min_dist_q == DIST_SENTINEL) && (min_id_q == '0))
		else $error("running minimum not cleared after result");

	// shared units are quiet whenever the block waits for an item
	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!cor_stat.busy && !sqd_stat.busy))
		else $error("arithmetic unit busy while idle");

endmodule
